[hw/rtl/esp_pkg.sv]
// Shared types, codes and the control store of the empty-slot sort move planner.
// Used by esp_seq, esp_dp and the top level; depends on nothing else.
package esp_pkg;

   // Fixed field widths of the request and response transfers and of the step counter.
   localparam int OP_W   = 2;
   localparam int SLOT_W = 6;
   localparam int PAT_W  = 2;
   localparam int VAL_W  = 6;
   localparam int ST_W   = 2;
   localparam int DATA_W = 16;
   localparam int UPC_W  = 5;

   // Request kinds.
   localparam logic [OP_W-1:0] OP_SET    = 2'd0;
   localparam logic [OP_W-1:0] OP_PAT_WR = 2'd1;
   localparam logic [OP_W-1:0] OP_APPLY  = 2'd2;
   localparam logic [OP_W-1:0] OP_PLAN   = 2'd3;

   // Response status codes.
   localparam logic [ST_W-1:0] ST_MOVE   = 2'd0;
   localparam logic [ST_W-1:0] ST_SORTED = 2'd1;
   localparam logic [ST_W-1:0] ST_ERROR  = 2'd2;

   // Control store addresses.
   localparam logic [UPC_W-1:0] U_INIT       = 5'd0;
   localparam logic [UPC_W-1:0] U_IDLE       = 5'd1;
   localparam logic [UPC_W-1:0] U_DISP       = 5'd2;
   localparam logic [UPC_W-1:0] U_SET        = 5'd3;
   localparam logic [UPC_W-1:0] U_PATW       = 5'd4;
   localparam logic [UPC_W-1:0] U_APPLY      = 5'd5;
   localparam logic [UPC_W-1:0] U_COPY       = 5'd6;
   localparam logic [UPC_W-1:0] U_COPY_END   = 5'd7;
   localparam logic [UPC_W-1:0] U_PLAN       = 5'd8;
   localparam logic [UPC_W-1:0] U_CHK_SORT   = 5'd9;
   localparam logic [UPC_W-1:0] U_CHK_FILL   = 5'd10;
   localparam logic [UPC_W-1:0] U_CHK_FB     = 5'd11;
   localparam logic [UPC_W-1:0] U_FB_SETUP   = 5'd12;
   localparam logic [UPC_W-1:0] U_FIND       = 5'd13;
   localparam logic [UPC_W-1:0] U_CHK_FOUND  = 5'd14;
   localparam logic [UPC_W-1:0] U_FILL_SETUP = 5'd15;
   localparam logic [UPC_W-1:0] U_MOVE       = 5'd16;
   localparam logic [UPC_W-1:0] U_MOVE_SRC   = 5'd17;
   localparam logic [UPC_W-1:0] U_SORTED     = 5'd18;
   localparam logic [UPC_W-1:0] U_ERR        = 5'd19;
   localparam logic [UPC_W-1:0] U_OUT        = 5'd20;
   localparam logic [UPC_W-1:0] U_OUT_WAIT   = 5'd21;

   // Datapath action of one control word.
   typedef enum logic [3:0] {
      A_NONE,
      A_INIT,
      A_IDLE,
      A_SET_WR,
      A_PAT_WR,
      A_COPY,
      A_SCAN,
      A_LOOP_CLR,
      A_FIND,
      A_FB_SETUP,
      A_FILL_SETUP,
      A_WR_DST,
      A_WR_SRC,
      A_RES_SORTED,
      A_RES_ERR,
      A_RES_LOAD
   } act_type;

   // Jump condition of one control word. A taken jump goes to the target (a dispatch
   // goes to the entry of the request kind), otherwise the step counter advances by one.
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_INIT_MORE,
      C_NO_REQ,
      C_DISPATCH,
      C_PAT_BAD,
      C_LOOP_MORE,
      C_SORTED,
      C_FILL,
      C_FB_BAD,
      C_NOT_FOUND,
      C_RSP_FREE
   } cond_type;

   typedef struct packed {
      act_type               act;
      cond_type              cond;
      logic [UPC_W-1:0]      target;
   } ucw_type;

   // Status flags from the datapath to the sequencer.
   typedef struct packed {
      logic                  req_valid;
      logic [OP_W-1:0]       op;
      logic                  init_more;
      logic                  loop_more;
      logic                  pat_bad;
      logic                  sorted;
      logic                  fill;
      logic                  fb_bad;
      logic                  not_found;
      logic                  rsp_free;
   } stat_type;

   function automatic ucw_type mk_cw(input act_type a, input cond_type c,
                                     input logic [UPC_W-1:0] t);
      ucw_type w;
      w.act    = a;
      w.cond   = c;
      w.target = t;
      return w;
   endfunction

   // The microprogram.
   function automatic ucw_type ucode_rom(input logic [UPC_W-1:0] addr);
      ucw_type w;
      case (addr)
         U_INIT:       w = mk_cw(A_INIT,       C_INIT_MORE, U_INIT);
         U_IDLE:       w = mk_cw(A_IDLE,       C_NO_REQ,    U_IDLE);
         U_DISP:       w = mk_cw(A_NONE,       C_DISPATCH,  U_IDLE);
         U_SET:        w = mk_cw(A_SET_WR,     C_ALWAYS,    U_IDLE);
         U_PATW:       w = mk_cw(A_PAT_WR,     C_ALWAYS,    U_IDLE);
         U_APPLY:      w = mk_cw(A_NONE,       C_PAT_BAD,   U_IDLE);
         U_COPY:       w = mk_cw(A_COPY,       C_LOOP_MORE, U_COPY);
         U_COPY_END:   w = mk_cw(A_NONE,       C_ALWAYS,    U_IDLE);
         U_PLAN:       w = mk_cw(A_SCAN,       C_LOOP_MORE, U_PLAN);
         U_CHK_SORT:   w = mk_cw(A_NONE,       C_SORTED,    U_SORTED);
         U_CHK_FILL:   w = mk_cw(A_LOOP_CLR,   C_FILL,      U_FIND);
         U_CHK_FB:     w = mk_cw(A_NONE,       C_FB_BAD,    U_ERR);
         U_FB_SETUP:   w = mk_cw(A_FB_SETUP,   C_ALWAYS,    U_MOVE);
         U_FIND:       w = mk_cw(A_FIND,       C_LOOP_MORE, U_FIND);
         U_CHK_FOUND:  w = mk_cw(A_NONE,       C_NOT_FOUND, U_ERR);
         U_FILL_SETUP: w = mk_cw(A_FILL_SETUP, C_NEVER,     U_IDLE);
         U_MOVE:       w = mk_cw(A_WR_DST,     C_NEVER,     U_IDLE);
         U_MOVE_SRC:   w = mk_cw(A_WR_SRC,     C_ALWAYS,    U_OUT);
         U_SORTED:     w = mk_cw(A_RES_SORTED, C_ALWAYS,    U_OUT);
         U_ERR:        w = mk_cw(A_RES_ERR,    C_NEVER,     U_IDLE);
         U_OUT:        w = mk_cw(A_RES_LOAD,   C_RSP_FREE,  U_IDLE);
         U_OUT_WAIT:   w = mk_cw(A_NONE,       C_ALWAYS,    U_OUT);
         default:      w = mk_cw(A_NONE,       C_ALWAYS,    U_IDLE);
      endcase
      return w;
   endfunction

   function automatic logic [UPC_W-1:0] dispatch_target(input logic [OP_W-1:0] op);
      logic [UPC_W-1:0] t;
      case (op)
         OP_SET:    t = U_SET;
         OP_PAT_WR: t = U_PATW;
         OP_APPLY:  t = U_APPLY;
         OP_PLAN:   t = U_PLAN;
         default:   t = U_IDLE;
      endcase
      return t;
   endfunction

endpackage

[hw/rtl/esp_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered read data.
// Generic; used by esp_dp for the layouts and the pattern store.
module esp_ram #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8,
   parameter int AW    = 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/esp_seq.sv]
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on esp_pkg for the control word, the flags and the microprogram.
module esp_seq (
   input  logic               clock,
   input  logic               reset,
   input  esp_pkg::stat_type  stat,
   output esp_pkg::act_type   act
);

   logic [esp_pkg::UPC_W-1:0] upc_ff;
   logic [esp_pkg::UPC_W-1:0] upc_in;
   esp_pkg::ucw_type          cw;
   logic                      take;

   assign cw = esp_pkg::ucode_rom(upc_ff);

   always_comb begin
      case (cw.cond)
         esp_pkg::C_NEVER:     take = 1'b0;
         esp_pkg::C_ALWAYS:    take = 1'b1;
         esp_pkg::C_INIT_MORE: take = stat.init_more;
         esp_pkg::C_NO_REQ:    take = !stat.req_valid;
         esp_pkg::C_DISPATCH:  take = 1'b1;
         esp_pkg::C_PAT_BAD:   take = stat.pat_bad;
         esp_pkg::C_LOOP_MORE: take = stat.loop_more;
         esp_pkg::C_SORTED:    take = stat.sorted;
         esp_pkg::C_FILL:      take = stat.fill;
         esp_pkg::C_FB_BAD:    take = stat.fb_bad;
         esp_pkg::C_NOT_FOUND: take = stat.not_found;
         esp_pkg::C_RSP_FREE:  take = stat.rsp_free;
         default:              take = 1'b1;
      endcase
   end

   // Next step.
   always_comb begin
      if (cw.cond == esp_pkg::C_DISPATCH) begin
         upc_in = esp_pkg::dispatch_target(stat.op);
      end else if (take) begin
         upc_in = cw.target;
      end else begin
         upc_in = upc_ff + esp_pkg::UPC_W'(1);
      end
   end

   // Control output.
   always_comb begin
      act = cw.act;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= esp_pkg::U_INIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

[hw/rtl/esp_dp.sv]
// Datapath of the move planner: request and response registers, layout and
// pattern memories, scan counter and search flags. Depends on esp_pkg and esp_ram.
module esp_dp #(
   parameter int SLOT_COUNT    = 35,
   parameter int PATTERN_COUNT = 4,
   parameter int ITEM_BITS     = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  esp_pkg::act_type            act,
   output esp_pkg::stat_type           stat,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [esp_pkg::OP_W-1:0]    req_op,
   input  logic [esp_pkg::SLOT_W-1:0]  req_slot,
   input  logic [esp_pkg::PAT_W-1:0]   req_pattern,
   input  logic [esp_pkg::VAL_W-1:0]   req_value,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [esp_pkg::SLOT_W-1:0]  rsp_from,
   output logic [esp_pkg::SLOT_W-1:0]  rsp_to,
   output logic [esp_pkg::ST_W-1:0]    rsp_status
);

   localparam int IDX_W     = $clog2(SLOT_COUNT);
   localparam int CTR_W     = $clog2(SLOT_COUNT + 1);
   localparam int PAT_DEPTH = PATTERN_COUNT * SLOT_COUNT;
   localparam int PAT_AW    = $clog2(PAT_DEPTH);

   localparam logic [IDX_W-1:0]             LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
   localparam logic [CTR_W-1:0]             CTR_END   = CTR_W'(SLOT_COUNT);
   localparam logic [PAT_AW-1:0]            LAST_PAT  = PAT_AW'(PAT_DEPTH - 1);
   localparam logic [PAT_AW-1:0]            PAT_SLOTS = PAT_AW'(SLOT_COUNT);
   localparam logic [IDX_W:0]               ID_LIM    = (IDX_W + 1)'(SLOT_COUNT - 2);
   localparam logic [esp_pkg::SLOT_W:0]     SLOT_LIM  = (esp_pkg::SLOT_W + 1)'(SLOT_COUNT);
   localparam logic [esp_pkg::PAT_W+1:0]    PAT_LIM   = (esp_pkg::PAT_W + 2)'(PATTERN_COUNT);

   // Reset content: slot i holds i, the last two slots are empty.
   function automatic logic [ITEM_BITS-1:0] ident_entry(input logic [IDX_W-1:0] i);
      logic [ITEM_BITS-1:0] v;
      if ({1'b0, i} < ID_LIM) begin
         v = ITEM_BITS'(i);
      end else begin
         v = '0;
      end
      return v;
   endfunction

   // Request registers.
   logic [esp_pkg::OP_W-1:0]   op_ff,   op_in;
   logic [esp_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [esp_pkg::PAT_W-1:0]  pat_ff,  pat_in;
   logic [ITEM_BITS-1:0]       val_ff,  val_in;

   // Scan pipeline.
   logic [CTR_W-1:0]  ctr_ff, ctr_in;
   logic              pv_ff, pv_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;

   // Power-up fill.
   logic [PAT_AW-1:0] init_addr_ff, init_addr_in;
   logic [IDX_W-1:0]  init_slot_ff, init_slot_in;
   logic              init_row0_ff, init_row0_in;

   // Search results.
   logic                 diff_ff,     diff_in;
   logic                 fill_ok_ff,  fill_ok_in;
   logic [IDX_W-1:0]     fill_idx_ff, fill_idx_in;
   logic [ITEM_BITS-1:0] fill_val_ff, fill_val_in;
   logic                 hole_ok_ff,  hole_ok_in;
   logic [IDX_W-1:0]     hole_idx_ff, hole_idx_in;
   logic                 mis_ok_ff,   mis_ok_in;
   logic [IDX_W-1:0]     mis_idx_ff,  mis_idx_in;
   logic [ITEM_BITS-1:0] mis_val_ff,  mis_val_in;
   logic                 found_ff,    found_in;
   logic [IDX_W-1:0]     mv_src_ff,   mv_src_in;
   logic [IDX_W-1:0]     mv_dst_ff,   mv_dst_in;
   logic [ITEM_BITS-1:0] mv_val_ff,   mv_val_in;

   // Result staging and output register.
   logic [IDX_W-1:0]           res_from_ff, res_from_in;
   logic [IDX_W-1:0]           res_to_ff,   res_to_in;
   logic [esp_pkg::ST_W-1:0]   res_st_ff,   res_st_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [esp_pkg::SLOT_W-1:0] rsp_from_ff, rsp_from_in;
   logic [esp_pkg::SLOT_W-1:0] rsp_to_ff,   rsp_to_in;
   logic [esp_pkg::ST_W-1:0]   rsp_st_ff,   rsp_st_in;

   // Memory ports.
   logic                 cur_we,  tgt_we,  pat_we;
   logic [IDX_W-1:0]     cur_waddr, tgt_waddr;
   logic [PAT_AW-1:0]    pat_waddr, pat_raddr;
   logic [ITEM_BITS-1:0] cur_wdata, tgt_wdata, pat_wdata;
   logic [ITEM_BITS-1:0] cur_rdata, tgt_rdata, pat_rdata;

   logic              rd_go;
   logic              slot_ok;
   logic              pat_ok;
   logic              rsp_free;
   logic [IDX_W-1:0]  cidx;
   logic [IDX_W-1:0]  slot_idx;
   logic [PAT_AW-1:0] pat_base;

   assign cidx     = ctr_ff[IDX_W-1:0];
   assign slot_idx = slot_ff[IDX_W-1:0];
   assign slot_ok  = {1'b0, slot_ff} < SLOT_LIM;
   assign pat_ok   = {2'b00, pat_ff} < PAT_LIM;
   assign pat_base = PAT_AW'(pat_ff) * PAT_SLOTS;
   assign rd_go    = (act inside {esp_pkg::A_SCAN, esp_pkg::A_FIND, esp_pkg::A_COPY})
                     && (ctr_ff < CTR_END);
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign pat_raddr = pat_base + PAT_AW'(cidx);

   esp_ram #(.DEPTH(SLOT_COUNT), .WIDTH(ITEM_BITS), .AW(IDX_W)) u_cur (
      .clock (clock),
      .we    (cur_we),
      .waddr (cur_waddr),
      .wdata (cur_wdata),
      .raddr (cidx),
      .rdata (cur_rdata)
   );

   esp_ram #(.DEPTH(SLOT_COUNT), .WIDTH(ITEM_BITS), .AW(IDX_W)) u_tgt (
      .clock (clock),
      .we    (tgt_we),
      .waddr (tgt_waddr),
      .wdata (tgt_wdata),
      .raddr (cidx),
      .rdata (tgt_rdata)
   );

   esp_ram #(.DEPTH(PAT_DEPTH), .WIDTH(ITEM_BITS), .AW(PAT_AW)) u_pat (
      .clock (clock),
      .we    (pat_we),
      .waddr (pat_waddr),
      .wdata (pat_wdata),
      .raddr (pat_raddr),
      .rdata (pat_rdata)
   );

   // Memory write ports.
   always_comb begin
      cur_we    = 1'b0;
      cur_waddr = slot_idx;
      cur_wdata = val_ff;
      tgt_we    = 1'b0;
      tgt_waddr = slot_idx;
      tgt_wdata = val_ff;
      pat_we    = 1'b0;
      pat_waddr = pat_base + PAT_AW'(slot_idx);
      pat_wdata = val_ff;
      case (act)
         esp_pkg::A_INIT: begin
            pat_we    = 1'b1;
            pat_waddr = init_addr_ff;
            pat_wdata = ident_entry(init_slot_ff);
            cur_we    = init_row0_ff;
            cur_waddr = init_slot_ff;
            cur_wdata = ident_entry(init_slot_ff);
            tgt_we    = init_row0_ff;
            tgt_waddr = init_slot_ff;
            tgt_wdata = ident_entry(init_slot_ff);
         end
         esp_pkg::A_SET_WR: begin
            cur_we = slot_ok;
            tgt_we = slot_ok;
         end
         esp_pkg::A_PAT_WR: begin
            pat_we = slot_ok && pat_ok;
         end
         esp_pkg::A_COPY: begin
            tgt_we    = pv_ff;
            tgt_waddr = rd_idx_ff;
            tgt_wdata = pat_rdata;
         end
         esp_pkg::A_WR_DST: begin
            cur_we    = 1'b1;
            cur_waddr = mv_dst_ff;
            cur_wdata = mv_val_ff;
         end
         esp_pkg::A_WR_SRC: begin
            cur_we    = 1'b1;
            cur_waddr = mv_src_ff;
            cur_wdata = '0;
         end
         default: begin
            cur_we = 1'b0;
         end
      endcase
   end

   // Register next values.
   always_comb begin
      op_in        = op_ff;
      slot_in      = slot_ff;
      pat_in       = pat_ff;
      val_in       = val_ff;
      ctr_in       = rd_go ? ctr_ff + CTR_W'(1) : ctr_ff;
      pv_in        = rd_go;
      rd_idx_in    = cidx;
      init_addr_in = init_addr_ff;
      init_slot_in = init_slot_ff;
      init_row0_in = init_row0_ff;
      diff_in      = diff_ff;
      fill_ok_in   = fill_ok_ff;
      fill_idx_in  = fill_idx_ff;
      fill_val_in  = fill_val_ff;
      hole_ok_in   = hole_ok_ff;
      hole_idx_in  = hole_idx_ff;
      mis_ok_in    = mis_ok_ff;
      mis_idx_in   = mis_idx_ff;
      mis_val_in   = mis_val_ff;
      found_in     = found_ff;
      mv_src_in    = mv_src_ff;
      mv_dst_in    = mv_dst_ff;
      mv_val_in    = mv_val_ff;
      res_from_in  = res_from_ff;
      res_to_in    = res_to_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_from_in  = rsp_from_ff;
      rsp_to_in    = rsp_to_ff;
      rsp_st_in    = rsp_st_ff;

      case (act)
         esp_pkg::A_INIT: begin
            init_addr_in = init_addr_ff + PAT_AW'(1);
            if (init_slot_ff == LAST_IDX) begin
               init_slot_in = '0;
               init_row0_in = 1'b0;
            end else begin
               init_slot_in = init_slot_ff + IDX_W'(1);
            end
         end
         esp_pkg::A_IDLE: begin
            op_in      = req_op;
            slot_in    = req_slot;
            pat_in     = req_pattern;
            val_in     = ITEM_BITS'(req_value);
            ctr_in     = '0;
            pv_in      = 1'b0;
            diff_in    = 1'b0;
            fill_ok_in = 1'b0;
            hole_ok_in = 1'b0;
            mis_ok_in  = 1'b0;
            found_in   = 1'b0;
         end
         esp_pkg::A_SCAN: begin
            // One slot per cycle: compare, note the first fillable hole, the
            // first hole and the first misplaced item.
            if (pv_ff) begin
               if (cur_rdata != tgt_rdata) begin
                  diff_in = 1'b1;
               end
               if (!fill_ok_ff && cur_rdata == '0 && tgt_rdata != '0) begin
                  fill_ok_in  = 1'b1;
                  fill_idx_in = rd_idx_ff;
                  fill_val_in = tgt_rdata;
               end
               if (!hole_ok_ff && cur_rdata == '0) begin
                  hole_ok_in  = 1'b1;
                  hole_idx_in = rd_idx_ff;
               end
               if (!mis_ok_ff && cur_rdata != '0 && cur_rdata != tgt_rdata) begin
                  mis_ok_in  = 1'b1;
                  mis_idx_in = rd_idx_ff;
                  mis_val_in = cur_rdata;
               end
            end
         end
         esp_pkg::A_LOOP_CLR: begin
            ctr_in   = '0;
            pv_in    = 1'b0;
            found_in = 1'b0;
         end
         esp_pkg::A_FIND: begin
            if (pv_ff && !found_ff && cur_rdata == fill_val_ff) begin
               found_in  = 1'b1;
               mv_src_in = rd_idx_ff;
            end
         end
         esp_pkg::A_FB_SETUP: begin
            mv_src_in = mis_idx_ff;
            mv_dst_in = hole_idx_ff;
            mv_val_in = mis_val_ff;
         end
         esp_pkg::A_FILL_SETUP: begin
            mv_dst_in = fill_idx_ff;
            mv_val_in = fill_val_ff;
         end
         esp_pkg::A_WR_SRC: begin
            res_from_in = mv_src_ff;
            res_to_in   = mv_dst_ff;
            res_st_in   = esp_pkg::ST_MOVE;
         end
         esp_pkg::A_RES_SORTED: begin
            res_from_in = '0;
            res_to_in   = LAST_IDX;
            res_st_in   = esp_pkg::ST_SORTED;
         end
         esp_pkg::A_RES_ERR: begin
            res_from_in = '0;
            res_to_in   = '0;
            res_st_in   = esp_pkg::ST_ERROR;
         end
         esp_pkg::A_RES_LOAD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_from_in  = esp_pkg::SLOT_W'(res_from_ff);
               rsp_to_in    = esp_pkg::SLOT_W'(res_to_ff);
               rsp_st_in    = res_st_ff;
            end
         end
         default: begin
            op_in = op_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff       <= '0;
         pv_ff        <= 1'b0;
         init_addr_ff <= '0;
         init_slot_ff <= '0;
         init_row0_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctr_ff       <= ctr_in;
         pv_ff        <= pv_in;
         init_addr_ff <= init_addr_in;
         init_slot_ff <= init_slot_in;
         init_row0_ff <= init_row0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      slot_ff     <= slot_in;
      pat_ff      <= pat_in;
      val_ff      <= val_in;
      rd_idx_ff   <= rd_idx_in;
      diff_ff     <= diff_in;
      fill_ok_ff  <= fill_ok_in;
      fill_idx_ff <= fill_idx_in;
      fill_val_ff <= fill_val_in;
      hole_ok_ff  <= hole_ok_in;
      hole_idx_ff <= hole_idx_in;
      mis_ok_ff   <= mis_ok_in;
      mis_idx_ff  <= mis_idx_in;
      mis_val_ff  <= mis_val_in;
      found_ff    <= found_in;
      mv_src_ff   <= mv_src_in;
      mv_dst_ff   <= mv_dst_in;
      mv_val_ff   <= mv_val_in;
      res_from_ff <= res_from_in;
      res_to_ff   <= res_to_in;
      res_st_ff   <= res_st_in;
      rsp_from_ff <= rsp_from_in;
      rsp_to_ff   <= rsp_to_in;
      rsp_st_ff   <= rsp_st_in;
   end

   always_comb begin
      stat.req_valid = req_tvalid;
      stat.op        = op_ff;
      stat.init_more = init_addr_ff != LAST_PAT;
      stat.loop_more = !(pv_ff && rd_idx_ff == LAST_IDX);
      stat.pat_bad   = !pat_ok;
      stat.sorted    = !diff_ff;
      stat.fill      = fill_ok_ff;
      stat.fb_bad    = !(hole_ok_ff && mis_ok_ff);
      stat.not_found = !found_ff;
      stat.rsp_free  = rsp_free;
   end

   assign req_tready = (act == esp_pkg::A_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_from   = rsp_from_ff;
   assign rsp_to     = rsp_to_ff;
   assign rsp_status = rsp_st_ff;

   // A planned move never takes an item from the slot it puts it into.
   a_move_distinct: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_st_ff == esp_pkg::ST_MOVE) |-> (rsp_from_ff != rsp_to_ff))
      else $error("move result with equal source and destination");

   // The fill path only commits after the source search succeeded.
   a_fill_found: assert property (@(posedge clock) disable iff (reset)
      (act == esp_pkg::A_FILL_SETUP) |-> found_ff)
      else $error("fill move set up without a source");

   a_wr_distinct: assert property (@(posedge clock) disable iff (reset)
      (act == esp_pkg::A_WR_DST) |-> (mv_dst_ff != mv_src_ff))
      else $error("move writes destination equal to source");

   a_pipe_idx: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> (rd_idx_ff <= LAST_IDX))
      else $error("scan read beyond the last slot");

endmodule

[hw/rtl/empty_slot_sort_move_planner.sv]
// Top level of the empty-slot sort move planner: stream packing around the
// microcode sequencer (esp_seq) and the datapath (esp_dp). Depends on esp_pkg.
//
// Usage: requests arrive on the req_ stream, one transfer per command. The
// command kind travels in req_tuser: set a slot in both layouts, write a
// pattern entry, copy a pattern into the target layout, or plan one move.
// Only a plan command produces a response transfer on the rsp_ stream, with
// the source and destination slots in rsp_tdata and the status in rsp_tuser.
// Timing: one command is worked on at a time. A pattern copy makes one pass
// over the pattern memory and a plan up to two passes over the current layout
// memory, one slot per cycle through its read port. After reset the block
// fills both layouts and every pattern with the identity order, last two slots
// empty, with req_tready low throughout.
// The response sits in an output register: the block takes the next command
// while it waits, and only a further plan command waits for rsp_tready.
module empty_slot_sort_move_planner #(
   parameter int SLOT_COUNT    = 35,
   parameter int PATTERN_COUNT = 4,
   parameter int ITEM_BITS     = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [5:0] slot, [7:6] pattern, [13:8] item_value, [15:14] zero
   input  logic [esp_pkg::DATA_W-1:0]    req_tdata,
   // [1:0] operation
   input  logic [esp_pkg::OP_W-1:0]      req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [5:0] from_slot, [11:6] to_slot, [15:12] zero
   output logic [esp_pkg::DATA_W-1:0]    rsp_tdata,
   // [1:0] status
   output logic [esp_pkg::ST_W-1:0]      rsp_tuser
);

   localparam int PAT_LO = esp_pkg::SLOT_W;
   localparam int VAL_LO = esp_pkg::SLOT_W + esp_pkg::PAT_W;
   localparam int RSP_PAD = esp_pkg::DATA_W - 2 * esp_pkg::SLOT_W;

   esp_pkg::act_type            act;
   esp_pkg::stat_type           stat;
   logic [esp_pkg::SLOT_W-1:0]  req_slot;
   logic [esp_pkg::PAT_W-1:0]   req_pattern;
   logic [esp_pkg::VAL_W-1:0]   req_value;
   logic [esp_pkg::SLOT_W-1:0]  rsp_from;
   logic [esp_pkg::SLOT_W-1:0]  rsp_to;

   assign req_slot    = req_tdata[esp_pkg::SLOT_W-1:0];
   assign req_pattern = req_tdata[PAT_LO +: esp_pkg::PAT_W];
   assign req_value   = req_tdata[VAL_LO +: esp_pkg::VAL_W];
   assign rsp_tdata   = {{RSP_PAD{1'b0}}, rsp_to, rsp_from};

   esp_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .act   (act)
   );

   esp_dp #(
      .SLOT_COUNT    (SLOT_COUNT),
      .PATTERN_COUNT (PATTERN_COUNT),
      .ITEM_BITS     (ITEM_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .act         (act),
      .stat        (stat),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_op      (req_tuser),
      .req_slot    (req_slot),
      .req_pattern (req_pattern),
      .req_value   (req_value),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_from    (rsp_from),
      .rsp_to      (rsp_to),
      .rsp_status  (rsp_tuser)
   );

endmodule
